// File: sv/fir_pkg.sv
// Shared constants and codes for the ring-buffer FIR filter.
// No dependencies; every other file of the block imports this package.
package fir_pkg;

    localparam int MAX_TAPS    = 64;
    localparam int SAMPLE_BITS = 24;
    localparam int COEF_BITS   = 16;
    localparam int ACC_BITS    = 48;

    localparam int ADDR_BITS   = $clog2(MAX_TAPS);
    localparam int TAPS_BITS   = $clog2(MAX_TAPS + 1);
    localparam int PROD_BITS   = SAMPLE_BITS + COEF_BITS;
    localparam int FRAC_SHIFT  = COEF_BITS - 1;
    localparam int Q_BITS      = ACC_BITS + 1 - FRAC_SHIFT;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = TAPS_BITS;

    localparam logic [CFG_IDX_BITS-1:0] CFG_FILTER_ENABLE = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_TAP_COUNT     = CFG_IDX_BITS'(1);

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_COEF   = 1'b1;

endpackage

// File: sv/fir_if.sv
// Handshake channels of the FIR filter: input items, result words, config writes.
// Depends on fir_pkg for field widths.
interface fir_in_if;
    import fir_pkg::*;
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic        [ADDR_BITS-1:0]   coef_index;
    logic signed [COEF_BITS-1:0]   coef_value;

    modport source (output valid, action, sample_in, coef_index, coef_value, input ready);
    modport sink   (input valid, action, sample_in, coef_index, coef_value, output ready);
endinterface

interface fir_out_if;
    import fir_pkg::*;
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;

    modport source (output valid, sample_out, input ready);
    modport sink   (input valid, sample_out, output ready);
endinterface

interface fir_cfg_if;
    import fir_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/fir_sample_mem.sv
// Circular sample store: one write port, one registered read port.
// Per-entry valid bits make unwritten entries read as zero after reset. Uses fir_pkg.
module fir_sample_mem (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_we,
    input  logic [fir_pkg::ADDR_BITS-1:0]          i_waddr,
    input  logic signed [fir_pkg::SAMPLE_BITS-1:0] i_wdata,
    input  logic [fir_pkg::ADDR_BITS-1:0]          i_raddr,
    output logic signed [fir_pkg::SAMPLE_BITS-1:0] o_rdata
);
    import fir_pkg::*;

    logic signed [SAMPLE_BITS-1:0] r_mem [MAX_TAPS];
    logic        [MAX_TAPS-1:0]    r_valid;
    logic signed [SAMPLE_BITS-1:0] r_rdata;
    logic                          r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            r_rd_ok <= r_valid[i_raddr];
        end
    end

    assign o_rdata = r_rd_ok ? r_rdata : '0;

endmodule

// File: sv/fir_coef_mem.sv
// Coefficient store: one write port, one registered read port, no reset.
// Uses fir_pkg for depth and width.
module fir_coef_mem (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [fir_pkg::ADDR_BITS-1:0]        i_waddr,
    input  logic signed [fir_pkg::COEF_BITS-1:0] i_wdata,
    input  logic [fir_pkg::ADDR_BITS-1:0]        i_raddr,
    output logic signed [fir_pkg::COEF_BITS-1:0] o_rdata
);
    import fir_pkg::*;

    logic signed [COEF_BITS-1:0] r_mem [MAX_TAPS];
    logic signed [COEF_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/fir_mac.sv
// Shared multiply-accumulate unit with a registered product stage,
// plus rounding and saturation of the accumulator to the sample format. Uses fir_pkg.
module fir_mac (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_clear,
    input  logic                                   i_valid,
    input  logic signed [fir_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic signed [fir_pkg::COEF_BITS-1:0]   i_coef,
    output logic                                   o_busy,
    output logic signed [fir_pkg::SAMPLE_BITS-1:0] o_result
);
    import fir_pkg::*;

    localparam logic [ACC_BITS:0] RND_HALF = (ACC_BITS + 1)'(1) << (COEF_BITS - 2);
    localparam logic [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

    logic signed [PROD_BITS-1:0] r_prod;
    logic                        r_prod_valid;
    logic        [ACC_BITS-1:0]  r_acc;
    logic        [ACC_BITS:0]    rnd;
    logic        [Q_BITS-1:0]    quot;
    logic        [Q_BITS-SAMPLE_BITS:0] upper;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
        end else if (i_clear) begin
            r_prod_valid <= 1'b0;
        end else begin
            r_prod_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_sample * i_coef;
        if (i_clear) begin
            r_acc <= '0;
        end else if (r_prod_valid) begin
            r_acc <= r_acc + {{(ACC_BITS - PROD_BITS){r_prod[PROD_BITS-1]}}, r_prod};
        end
    end

    // Add half an output step, then keep the upper bits: a floor shift.
    assign rnd   = {r_acc[ACC_BITS-1], r_acc} + RND_HALF;
    assign quot  = rnd[ACC_BITS:FRAC_SHIFT];
    assign upper = quot[Q_BITS-1:SAMPLE_BITS-1];

    always_comb begin
        if ((&upper) || !(|upper)) begin
            o_result = quot[SAMPLE_BITS-1:0];
        end else if (quot[Q_BITS-1]) begin
            o_result = SAT_MIN;
        end else begin
            o_result = SAT_MAX;
        end
    end

    assign o_busy = r_prod_valid;

endmodule

// File: sv/fir_filter_ring_buffer_top.sv
// Direct-form FIR filter over a circular sample store, built around two simple dual-port
// memories and one shared multiply-accumulate. A filtered sample steps one tap per cycle
// through the memory read port and the multiplier; a bypassed sample and a coefficient
// write do not use the multiply-accumulate.
// The finished word waits in an output register, so the next item is taken meanwhile.
// Configuration is accepted at any time; write it only while the block is idle.
// Depends on fir_pkg, the channel interfaces, fir_sample_mem, fir_coef_mem and fir_mac.
module fir_filter_ring_buffer_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fir_in_if.sink    i_in,
    fir_cfg_if.sink   i_cfg,
    fir_out_if.source o_out
);
    import fir_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MAC   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } t_state;

    t_state                        r_state;
    t_state                        n_state;
    logic                          r_enable;
    logic [TAPS_BITS-1:0]          r_tap_count;
    logic [ADDR_BITS-1:0]          r_wp;
    logic [ADDR_BITS-1:0]          r_rd_idx;
    logic [ADDR_BITS-1:0]          r_n;
    logic [ADDR_BITS-1:0]          r_last;
    logic                          r_rd_pend;
    logic signed [SAMPLE_BITS-1:0] r_result;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_data;

    logic                          in_fire;
    logic                          cfg_fire;
    logic                          is_coef;
    logic [TAPS_BITS-1:0]          taps;
    logic [ADDR_BITS-1:0]          newest;
    logic [TAPS_BITS-1:0]          newest_inc;
    logic [ADDR_BITS-1:0]          wp_next;
    logic                          ring_we;
    logic                          coef_we;
    logic                          out_free;
    logic                          mac_busy;
    logic signed [SAMPLE_BITS-1:0] mac_result;
    logic signed [SAMPLE_BITS-1:0] ring_rdata;
    logic signed [COEF_BITS-1:0]   coef_rdata;

    assign in_fire  = i_in.valid && i_in.ready;
    assign cfg_fire = i_cfg.valid && i_cfg.ready;
    assign is_coef  = (i_in.action == ACT_COEF);
    assign out_free = !r_out_valid || o_out.ready;

    // A tap count of zero acts as one, anything beyond the store as the full store.
    always_comb begin
        if (r_tap_count == '0) begin
            taps = TAPS_BITS'(1);
        end else if (r_tap_count > TAPS_BITS'(MAX_TAPS)) begin
            taps = TAPS_BITS'(MAX_TAPS);
        end else begin
            taps = r_tap_count;
        end
    end

    // A stale pointer restarts at zero before the sample is written.
    assign newest     = (TAPS_BITS'(r_wp) >= taps) ? '0 : r_wp;
    assign newest_inc = TAPS_BITS'(newest) + TAPS_BITS'(1);
    assign wp_next    = (newest_inc >= taps) ? '0 : newest_inc[ADDR_BITS-1:0];

    assign ring_we = in_fire && !is_coef && r_enable;
    assign coef_we = in_fire && is_coef && (TAPS_BITS'(i_in.coef_index) < TAPS_BITS'(MAX_TAPS));

    fir_sample_mem u_sample_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (ring_we),
        .i_waddr (newest),
        .i_wdata (i_in.sample_in),
        .i_raddr (r_rd_idx),
        .o_rdata (ring_rdata)
    );

    fir_coef_mem u_coef_mem (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (i_in.coef_index),
        .i_wdata (i_in.coef_value),
        .i_raddr (r_n),
        .o_rdata (coef_rdata)
    );

    fir_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (ring_we),
        .i_valid  (r_rd_pend),
        .i_sample (ring_rdata),
        .i_coef   (coef_rdata),
        .o_busy   (mac_busy),
        .o_result (mac_result)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_fire && !is_coef) begin
                    n_state = r_enable ? ST_MAC : ST_DONE;
                end
            end
            ST_MAC: begin
                if (r_n == r_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_rd_pend && !mac_busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_enable    <= 1'b0;
            r_tap_count <= TAPS_BITS'(MAX_TAPS);
            r_wp        <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= (r_state == ST_MAC);
            if (cfg_fire) begin
                if (i_cfg.index == CFG_FILTER_ENABLE) begin
                    r_enable <= i_cfg.data[0];
                end else if (i_cfg.index == CFG_TAP_COUNT) begin
                    r_tap_count <= i_cfg.data;
                end
            end
            if (ring_we) begin
                r_wp <= wp_next;
            end
            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    // Datapath registers: read addresses walk newest-to-oldest around the ring.
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_rd_idx <= newest;
            r_n      <= '0;
            r_last   <= ADDR_BITS'(taps - TAPS_BITS'(1));
        end else if (r_state == ST_MAC) begin
            r_n      <= r_n + ADDR_BITS'(1);
            r_rd_idx <= (r_rd_idx == '0) ? r_last : r_rd_idx - ADDR_BITS'(1);
        end
        if (in_fire && !is_coef && !r_enable) begin
            r_result <= i_in.sample_in;
        end else if (r_state == ST_DRAIN && !r_rd_pend && !mac_busy) begin
            r_result <= mac_result;
        end
        if (r_state == ST_DONE && out_free) begin
            r_out_data <= r_result;
        end
    end

    assign i_in.ready       = (r_state == ST_IDLE);
    assign i_cfg.ready      = 1'b1;
    assign o_out.valid      = r_out_valid;
    assign o_out.sample_out = r_out_data;

endmodule
